// ===== src/wls_pkg.sv =====
`timescale 1ns / 1ps
package wls_pkg;

  // Default build parameters
  localparam int POS_BITS_DEF     = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC table length and iteration counter width (covers table and divider)
  localparam int TABLE_LEN = 24;
  localparam int ITER_W    = 5;

  // pi in Q16 and CORDIC 1/K in Q30
  localparam int PI_Q16       = 205887;
  localparam int INV_GAIN_Q30 = 652032874;

  // Configuration space
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_GOAL_RADIUS  = 3'd0,
    REG_CROSS_LIMIT  = 3'd1,
    REG_HEADING_GAIN = 3'd2,
    REG_RATE_LIMIT   = 3'd3,
    REG_CRUISE_SPEED = 3'd4
  } reg_idx_e;

  localparam logic [14:0] GOAL_RADIUS_RST  = 15'd307;
  localparam logic [14:0] CROSS_LIMIT_RST  = 15'd1024;
  localparam logic [7:0]  HEADING_GAIN_RST = 8'd32;
  localparam logic [14:0] RATE_LIMIT_RST   = 15'd8192;
  localparam logic [14:0] CRUISE_SPEED_RST = 15'd2048;

  typedef struct packed {
    logic [14:0] goal_radius;
    logic [14:0] cross_limit;
    logic [7:0]  heading_gain;
    logic [14:0] rate_limit;
    logic [14:0] cruise_speed;
  } cfg_t;

  // Controller states, one-hot; the datapath acts on the current state
  typedef enum logic [21:0] {
    ST_IDLE     = 22'd1 << 0,
    ST_WP_SHIFT = 22'd1 << 1,
    ST_VEC_INIT = 22'd1 << 2,
    ST_VEC_STEP = 22'd1 << 3,
    ST_VEC_DONE = 22'd1 << 4,
    ST_ROT_INIT = 22'd1 << 5,
    ST_ROT_STEP = 22'd1 << 6,
    ST_ROT_DONE = 22'd1 << 7,
    ST_MUL_XS   = 22'd1 << 8,
    ST_MUL_YC   = 22'd1 << 9,
    ST_CROSS    = 22'd1 << 10,
    ST_DIV_STEP = 22'd1 << 11,
    ST_MUL_GE   = 22'd1 << 12,
    ST_MUL_PI   = 22'd1 << 13,
    ST_SAT      = 22'd1 << 14,
    ST_MUL_RATE = 22'd1 << 15,
    ST_RATE     = 22'd1 << 16,
    ST_MUL_DX2  = 22'd1 << 17,
    ST_MUL_DY2  = 22'd1 << 18,
    ST_MUL_R2   = 22'd1 << 19,
    ST_ARRIVE   = 22'd1 << 20,
    ST_EMIT     = 22'd1 << 21
  } state_e;

  typedef struct packed {
    state_e            op;
    logic [ITER_W-1:0] iter;
    logic              load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/wls_in_if.sv =====
`timescale 1ns / 1ps
interface wls_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;

  modport source (output valid, kind, pos_x, pos_y, heading, input ready);
  modport sink (input valid, kind, pos_x, pos_y, heading, output ready);
endinterface

// ===== src/wls_out_if.sv =====
`timescale 1ns / 1ps
interface wls_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] turn_rate;
  logic [14:0]        forward_speed;
  logic               arrived;
  logic signed [15:0] cross_error;

  modport source (output valid, turn_rate, forward_speed, arrived, cross_error, input ready);
  modport sink (input valid, turn_rate, forward_speed, arrived, cross_error, output ready);
endinterface

// ===== src/wls_cfg.sv =====
`timescale 1ns / 1ps
module wls_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wls_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output wls_pkg::cfg_t              cfg_o
);

  wls_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  // Register writes, masked to width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_radius  <= wls_pkg::GOAL_RADIUS_RST;
      cfg_q.cross_limit  <= wls_pkg::CROSS_LIMIT_RST;
      cfg_q.heading_gain <= wls_pkg::HEADING_GAIN_RST;
      cfg_q.rate_limit   <= wls_pkg::RATE_LIMIT_RST;
      cfg_q.cruise_speed <= wls_pkg::CRUISE_SPEED_RST;
    end else if (wr_en) begin
      case (idx)
        wls_pkg::REG_GOAL_RADIUS:  cfg_q.goal_radius  <= pwdata[14:0];
        wls_pkg::REG_CROSS_LIMIT:  cfg_q.cross_limit  <= pwdata[14:0];
        wls_pkg::REG_HEADING_GAIN: cfg_q.heading_gain <= pwdata[7:0];
        wls_pkg::REG_RATE_LIMIT:   cfg_q.rate_limit   <= pwdata[14:0];
        wls_pkg::REG_CRUISE_SPEED: cfg_q.cruise_speed <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      wls_pkg::REG_GOAL_RADIUS:  prdata = {17'd0, cfg_q.goal_radius};
      wls_pkg::REG_CROSS_LIMIT:  prdata = {17'd0, cfg_q.cross_limit};
      wls_pkg::REG_HEADING_GAIN: prdata = {24'd0, cfg_q.heading_gain};
      wls_pkg::REG_RATE_LIMIT:   prdata = {17'd0, cfg_q.rate_limit};
      wls_pkg::REG_CRUISE_SPEED: prdata = {17'd0, cfg_q.cruise_speed};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/wls_ctrl.sv =====
`timescale 1ns / 1ps
module wls_ctrl #(
  parameter int NSTEP = 16,
  parameter int DSTEP = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  input  wls_pkg::status_t status_i,
  output wls_pkg::cmd_t    cmd_o
);

  localparam logic [wls_pkg::ITER_W-1:0] NLAST = wls_pkg::ITER_W'(NSTEP - 1);
  localparam logic [wls_pkg::ITER_W-1:0] DLAST = wls_pkg::ITER_W'(DSTEP - 1);

  wls_pkg::state_e               state_q, state_d;
  logic [wls_pkg::ITER_W-1:0]    iter_q, iter_d;

  assign in_ready_o  = (state_q == wls_pkg::ST_IDLE);
  assign cmd_o.op    = state_q;
  assign cmd_o.iter  = iter_q;
  assign cmd_o.load  = in_valid_i && (state_q == wls_pkg::ST_IDLE);

  // Next state and iteration count
  always_comb begin
    state_d = state_q;
    iter_d  = '0;
    case (state_q)
      wls_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = in_kind_i ? wls_pkg::ST_MUL_XS : wls_pkg::ST_WP_SHIFT;
      end
      wls_pkg::ST_WP_SHIFT: state_d = wls_pkg::ST_VEC_INIT;
      wls_pkg::ST_VEC_INIT: state_d = wls_pkg::ST_VEC_STEP;
      wls_pkg::ST_VEC_STEP: begin
        if (iter_q == NLAST) state_d = wls_pkg::ST_VEC_DONE;
        else iter_d = iter_q + 1'b1;
      end
      wls_pkg::ST_VEC_DONE: state_d = wls_pkg::ST_ROT_INIT;
      wls_pkg::ST_ROT_INIT: state_d = wls_pkg::ST_ROT_STEP;
      wls_pkg::ST_ROT_STEP: begin
        if (iter_q == NLAST) state_d = wls_pkg::ST_ROT_DONE;
        else iter_d = iter_q + 1'b1;
      end
      wls_pkg::ST_ROT_DONE: state_d = wls_pkg::ST_IDLE;
      wls_pkg::ST_MUL_XS:   state_d = wls_pkg::ST_MUL_YC;
      wls_pkg::ST_MUL_YC:   state_d = wls_pkg::ST_CROSS;
      wls_pkg::ST_CROSS:    state_d = wls_pkg::ST_DIV_STEP;
      wls_pkg::ST_DIV_STEP: begin
        if (iter_q == DLAST) state_d = wls_pkg::ST_MUL_GE;
        else iter_d = iter_q + 1'b1;
      end
      wls_pkg::ST_MUL_GE:   state_d = wls_pkg::ST_MUL_PI;
      wls_pkg::ST_MUL_PI:   state_d = wls_pkg::ST_SAT;
      wls_pkg::ST_SAT:      state_d = wls_pkg::ST_MUL_RATE;
      wls_pkg::ST_MUL_RATE: state_d = wls_pkg::ST_RATE;
      wls_pkg::ST_RATE:     state_d = wls_pkg::ST_MUL_DX2;
      wls_pkg::ST_MUL_DX2:  state_d = wls_pkg::ST_MUL_DY2;
      wls_pkg::ST_MUL_DY2:  state_d = wls_pkg::ST_MUL_R2;
      wls_pkg::ST_MUL_R2:   state_d = wls_pkg::ST_ARRIVE;
      wls_pkg::ST_ARRIVE:   state_d = wls_pkg::ST_EMIT;
      wls_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = wls_pkg::ST_IDLE;
      end
      default: state_d = wls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wls_pkg::ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

endmodule

// ===== src/wls_dp.sv =====
`timescale 1ns / 1ps
module wls_dp #(
  parameter int POS_BITS   = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wls_pkg::cmd_t      cmd_i,
  input  wls_pkg::cfg_t      cfg_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  output wls_pkg::status_t   status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [15:0] turn_rate_o,
  output logic [14:0]        forward_speed_o,
  output logic               arrived_o,
  output logic signed [15:0] cross_error_o
);

  localparam int PW  = POS_BITS;
  localparam int AB  = ANGLE_BITS;
  localparam int DW  = PW + 1;
  localparam int CW  = (PW + 12 > 34) ? PW + 12 : 34;
  localparam int MA  = (DW > AB + 9) ? DW : AB + 9;
  localparam int MB  = 20;
  localparam int PRW = MA + MB;
  localparam int AW  = PW + 18;
  localparam int EW  = PW + 4;

  localparam logic signed [AW-1:0]  E_RND  = AW'(8192);
  localparam logic signed [EW-1:0]  E_MAX  = EW'(32767);
  localparam logic signed [EW-1:0]  E_MIN  = -EW'(32768);
  localparam logic signed [PRW-1:0] S_RND  = PRW'(1) <<< (AB + 2);
  localparam logic signed [PRW-1:0] S_MAX  = PRW'(65536);
  localparam logic signed [PRW-1:0] R_RND  = PRW'(32768);
  localparam logic signed [CW-1:0]  C_RND  = CW'(32768);
  localparam logic signed [CW-1:0]  U_MAX  = CW'(16384);
  localparam logic signed [33:0]    D_LIM  = 34'sd32767;
  localparam logic [31:0]           Z_RND  = 32'd1 << (31 - AB);
  localparam logic [AB-2:0]         Q_FULL = (AB-1)'(1) << (AB - 2);

  wls_pkg::state_e op;
  logic            ld;

  // Segment state
  logic signed [PW-1:0] start_x_q, start_y_q, goal_x_q, goal_y_q;
  logic [AB-1:0]        seg_angle_q;
  logic signed [15:0]   sin_q, cos_q;

  // Item and work registers
  logic signed [PW-1:0]  px_q, py_q;
  logic signed [15:0]    hd_q;
  logic signed [CW-1:0]  cx_q, cy_q;
  logic [31:0]           cz_q;
  logic                  zero_q, neg_q;
  logic signed [PRW-1:0] prod_q;
  logic signed [AW-1:0]  acc_q;
  logic signed [EW-1:0]  e_q;
  logic                  sat_q;
  logic [14:0]           rem_q;
  logic [AB-3:0]         quo_q;
  logic signed [17:0]    s_q;
  logic signed [15:0]    rate_q;
  logic [31:0]           sq_q;
  logic                  arr_q;

  // Output beat register
  logic                  out_valid_q;
  logic signed [15:0]    turn_q, cross_q;
  logic [14:0]           speed_q;
  logic                  arrived_q;

  assign op = cmd_i.op;
  assign ld = cmd_i.load;

  // Differences
  logic signed [DW-1:0] seg_dx, seg_dy, pdx, pdy, gdx, gdy;
  assign seg_dx = DW'(goal_x_q) - DW'(start_x_q);
  assign seg_dy = DW'(goal_y_q) - DW'(start_y_q);
  assign pdx    = DW'(px_q) - DW'(start_x_q);
  assign pdy    = DW'(py_q) - DW'(start_y_q);
  assign gdx    = DW'(px_q) - DW'(goal_x_q);
  assign gdy    = DW'(py_q) - DW'(goal_y_q);

  // Heading rescaled to the angle width
  logic [AB-1:0] h_ang;
  generate
    if (AB <= 16) begin : g_hd_narrow
      assign h_ang = hd_q[15 -: AB];
    end else begin : g_hd_wide
      assign h_ang = {hd_q, {(AB-16){1'b0}}};
    end
  endgenerate

  // Strategy angle and wrapped heading error
  logic [AB-2:0] smag;
  logic [AB-1:0] strat, err;
  logic          e_pos;
  assign e_pos = !e_q[EW-1] && (e_q != '0);
  assign smag  = sat_q ? Q_FULL : {1'b0, quo_q};
  assign strat = e_pos ? -AB'(smag) : AB'(smag);
  assign err   = seg_angle_q + strat - h_ang;

  // Cross-track error rounding, magnitude and limit
  logic signed [AW-1:0] cross_sum;
  logic signed [EW-1:0] e_d;
  logic [EW-1:0]        mag_d;
  logic [14:0]          lim;
  assign cross_sum = acc_q + AW'(prod_q) + E_RND;
  assign e_d       = EW'(cross_sum >>> 14);
  assign mag_d     = e_d[EW-1] ? EW'(-e_d) : EW'(e_d);
  assign lim       = (cfg_i.cross_limit == '0) ? 15'd1 : cfg_i.cross_limit;

  // Restoring division step
  logic [15:0] div_t;
  logic        div_ge;
  assign div_t  = {rem_q, 1'b0};
  assign div_ge = div_t >= {1'b0, lim};

  // Shared multiplier, registered product
  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic signed [PRW-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      wls_pkg::ST_MUL_XS: begin
        mul_a = MA'(pdx);
        mul_b = MB'(sin_q);
      end
      wls_pkg::ST_MUL_YC: begin
        mul_a = MA'(pdy);
        mul_b = MB'(cos_q);
      end
      wls_pkg::ST_MUL_GE: begin
        mul_a = MA'($signed(err));
        mul_b = MB'($signed({1'b0, cfg_i.heading_gain}));
      end
      wls_pkg::ST_MUL_PI: begin
        mul_a = MA'($signed(prod_q[AB+8:0]));
        mul_b = MB'(wls_pkg::PI_Q16);
      end
      wls_pkg::ST_MUL_RATE: begin
        mul_a = MA'(s_q);
        mul_b = MB'($signed({1'b0, cfg_i.rate_limit}));
      end
      wls_pkg::ST_MUL_DX2: begin
        mul_a = MA'(gdx);
        mul_b = MB'(gdx);
      end
      wls_pkg::ST_MUL_DY2: begin
        mul_a = MA'(gdy);
        mul_b = MB'(gdy);
      end
      wls_pkg::ST_MUL_R2: begin
        mul_a = MA'($signed({1'b0, cfg_i.goal_radius}));
        mul_b = MB'($signed({1'b0, cfg_i.goal_radius}));
      end
      default: ;
    endcase
  end
  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  // Gain stage rounding and clamp, rate rounding
  logic signed [PRW-1:0] s_sh, r_sh;
  logic signed [17:0]    s_d;
  assign s_sh = (prod_q + S_RND) >>> (AB + 3);
  assign r_sh = (prod_q + R_RND) >>> 16;
  always_comb begin
    if (s_sh > S_MAX) s_d = 18'sd65536;
    else if (s_sh < -S_MAX) s_d = -18'sd65536;
    else s_d = 18'(s_sh);
  end

  // Arrival range check
  logic in_range;
  assign in_range = (34'(gdx) <= D_LIM) && (34'(gdx) >= -D_LIM) &&
                    (34'(gdy) <= D_LIM) && (34'(gdy) >= -D_LIM);

  // CORDIC shared by vectoring and rotation
  logic signed [CW-1:0] vx0, vy0, cx_sh, cy_sh;
  logic [31:0]          at, zr, za;
  logic signed [31:0]   zs;
  assign vx0   = CW'(seg_dx) <<< 8;
  assign vy0   = CW'(seg_dy) <<< 8;
  assign cx_sh = cx_q >>> cmd_i.iter;
  assign cy_sh = cy_q >>> cmd_i.iter;
  assign at    = wls_pkg::atan_turn(cmd_i.iter);
  assign zr    = cz_q + Z_RND;
  assign za    = {seg_angle_q, {(32-AB){1'b0}}};
  assign zs    = $signed(za);

  // Final sine and cosine: round, fold back, clamp
  logic signed [CW-1:0] xr, yr, xn, yn;
  logic signed [15:0]   cos_d, sin_d;
  always_comb begin
    xr = (cx_q + C_RND) >>> 16;
    yr = (cy_q + C_RND) >>> 16;
    xn = neg_q ? -xr : xr;
    yn = neg_q ? -yr : yr;
    if (xn > U_MAX) cos_d = 16'sd16384;
    else if (xn < -U_MAX) cos_d = -16'sd16384;
    else cos_d = 16'(xn);
    if (yn > U_MAX) sin_d = 16'sd16384;
    else if (yn < -U_MAX) sin_d = -16'sd16384;
    else sin_d = 16'(yn);
  end

  // Segment state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q   <= '0;
      start_y_q   <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      seg_angle_q <= '0;
      sin_q       <= 16'sd0;
      cos_q       <= 16'sd16384;
    end else begin
      case (op)
        wls_pkg::ST_WP_SHIFT: begin
          start_x_q <= goal_x_q;
          start_y_q <= goal_y_q;
          goal_x_q  <= px_q;
          goal_y_q  <= py_q;
        end
        wls_pkg::ST_VEC_DONE: seg_angle_q <= zero_q ? '0 : zr[31 -: AB];
        wls_pkg::ST_ROT_DONE: begin
          sin_q <= sin_d;
          cos_q <= cos_d;
        end
        default: ;
      endcase
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    if (ld) begin
      px_q <= PW'(pos_x_i);
      py_q <= PW'(pos_y_i);
      hd_q <= heading_i;
    end
    case (op)
      wls_pkg::ST_VEC_INIT: begin
        zero_q <= (seg_dx == '0) && (seg_dy == '0);
        if (seg_dx[DW-1]) begin
          cx_q <= -vx0;
          cy_q <= -vy0;
          cz_q <= 32'h8000_0000;
        end else begin
          cx_q <= vx0;
          cy_q <= vy0;
          cz_q <= 32'd0;
        end
      end
      wls_pkg::ST_VEC_STEP: begin
        if (!cy_q[CW-1]) begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          cz_q <= cz_q - at;
        end
      end
      wls_pkg::ST_ROT_INIT: begin
        cx_q <= CW'(wls_pkg::INV_GAIN_Q30);
        cy_q <= '0;
        if (zs > 32'sh4000_0000 || zs < -32'sh4000_0000) begin
          cz_q  <= za + 32'h8000_0000;
          neg_q <= 1'b1;
        end else begin
          cz_q  <= za;
          neg_q <= 1'b0;
        end
      end
      wls_pkg::ST_ROT_STEP: begin
        if (!cz_q[31]) begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          cz_q <= cz_q + at;
        end
      end
      wls_pkg::ST_MUL_XS: prod_q <= mul_p;
      wls_pkg::ST_MUL_YC: begin
        acc_q  <= -AW'(prod_q);
        prod_q <= mul_p;
      end
      wls_pkg::ST_CROSS: begin
        e_q   <= e_d;
        sat_q <= mag_d >= EW'(lim);
        rem_q <= mag_d[14:0];
        quo_q <= '0;
      end
      wls_pkg::ST_DIV_STEP: begin
        rem_q <= div_ge ? 15'(div_t - {1'b0, lim}) : div_t[14:0];
        quo_q <= {quo_q[AB-4:0], div_ge};
      end
      wls_pkg::ST_MUL_GE:   prod_q <= mul_p;
      wls_pkg::ST_MUL_PI:   prod_q <= mul_p;
      wls_pkg::ST_SAT:      s_q <= s_d;
      wls_pkg::ST_MUL_RATE: prod_q <= mul_p;
      wls_pkg::ST_RATE:     rate_q <= 16'(r_sh);
      wls_pkg::ST_MUL_DX2:  prod_q <= mul_p;
      wls_pkg::ST_MUL_DY2: begin
        sq_q   <= prod_q[31:0];
        prod_q <= mul_p;
      end
      wls_pkg::ST_MUL_R2: begin
        sq_q   <= sq_q + prod_q[31:0];
        prod_q <= mul_p;
      end
      wls_pkg::ST_ARRIVE: arr_q <= in_range && (sq_q < prod_q[31:0]);
      default: ;
    endcase
  end

  // Output beat
  logic emit;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign emit = (op == wls_pkg::ST_EMIT) && status_o.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      turn_q    <= arr_q ? 16'sd0 : rate_q;
      speed_q   <= arr_q ? 15'd0 : cfg_i.cruise_speed;
      arrived_q <= arr_q;
      if (e_q > E_MAX) cross_q <= 16'sd32767;
      else if (e_q < E_MIN) cross_q <= -16'sd32768;
      else cross_q <= 16'(e_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign turn_rate_o     = turn_q;
  assign forward_speed_o = speed_q;
  assign arrived_o       = arrived_q;
  assign cross_error_o   = cross_q;

endmodule

// ===== src/waypoint_line_steering.sv =====
`timescale 1ns / 1ps
// Pose item: one result beat after accept, computed by the (ANGLE_BITS-2)-step restoring
// divider and eight shared-multiplier steps.
// Waypoint item: no result; the controller stays busy on the CORDIC until it is done.
// One item at a time; the next is taken once the controller is back in idle.
// Async active-low reset: registers to defaults, segment to origin, cosine one.
module waypoint_line_steering #(
  parameter int POS_BITS     = wls_pkg::POS_BITS_DEF,
  parameter int ANGLE_BITS   = wls_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = wls_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wls_in_if.sink                     in_i,
  wls_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wls_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int NSTEP = (CORDIC_STEPS > wls_pkg::TABLE_LEN) ? wls_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;

  wls_pkg::cfg_t    cfg;
  wls_pkg::cmd_t    cmd;
  wls_pkg::status_t status;

  wls_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wls_ctrl #(
    .NSTEP (NSTEP),
    .DSTEP (ANGLE_BITS - 2)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wls_dp #(
    .POS_BITS   (POS_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .pos_x_i         (in_i.pos_x),
    .pos_y_i         (in_i.pos_y),
    .heading_i       (in_i.heading),
    .status_o        (status),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .turn_rate_o     (out_o.turn_rate),
    .forward_speed_o (out_o.forward_speed),
    .arrived_o       (out_o.arrived),
    .cross_error_o   (out_o.cross_error)
  );

endmodule
